// ===== rtl/fpca_pkg.sv =====
package fpca_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int NUM_STOPS = 8;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic signed [15:0] ONE_Q     = 16'sd8192;
  localparam logic signed [15:0] NEG_ONE_Q = -16'sd8192;
  localparam logic signed [15:0] ZERO_Q    = 16'sd0;

  localparam logic [1:0] CMD_COMMANDER = 2'd0;
  localparam logic [1:0] CMD_RUNSTOP   = 2'd1;
  localparam logic [1:0] CMD_RC        = 2'd2;
  localparam logic [1:0] CMD_EVAL      = 2'd3;

  localparam logic [1:0] REG_CMD_AGE  = 2'd0;
  localparam logic [1:0] REG_STOP_AGE = 2'd1;
  localparam logic [1:0] REG_SLOTS    = 2'd2;

  localparam logic [3:0] SRC_NONE    = 4'd0;
  localparam logic [3:0] SRC_RUNSTOP = 4'd1;
  localparam logic [3:0] SRC_MANUAL  = 4'd2;
  localparam logic [3:0] SRC_SLOT0   = 4'd3;

  localparam logic [15:0] CMD_AGE_RST  = 16'd200;
  localparam logic [15:0] STOP_AGE_RST = 16'd2000;
  localparam logic [3:0]  SLOTS_RST    = 4'd6;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         slot;
    logic signed [15:0] steer_value;
    logic signed [15:0] throttle_value;
    logic signed [15:0] brake_value;
    logic               motion_ok;
    logic               auto_mode;
    logic               relay_on;
    logic [31:0]        stamp;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_steer;
    logic signed [15:0] out_throttle;
    logic signed [15:0] out_brake;
    logic [3:0]         steer_source;
    logic [3:0]         throttle_source;
    logic [3:0]         brake_source;
    logic               motion_on;
    logic               autonomous;
    logic               relay_enabled;
  } out_item_t;

  typedef struct packed {
    logic [15:0] cmd_age;
    logic [15:0] stop_age;
    logic [3:0]  slots;
    logic        clr;
  } cfg_t;

  typedef struct packed {
    logic apply;
    logic latch;
    logic check;
    logic load;
  } ctl_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PICK
  } state_t;

  function automatic logic is_fresh(logic [31:0] now, logic [31:0] t, logic [15:0] limit);
    logic [31:0] d;
    d = now - t;
    return d[31] | (d < {16'b0, limit});
  endfunction

  function automatic logic in_unit(logic signed [15:0] v);
    return (v <= ONE_Q) && (v >= NEG_ONE_Q);
  endfunction

  function automatic logic in_brake(logic signed [15:0] v);
    return (v <= ONE_Q) && (v >= ZERO_Q);
  endfunction

endpackage

// ===== rtl/fpca_if.sv =====
interface fpca_in_if import fpca_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fpca_out_if import fpca_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/fpca_cfg.sv =====
module fpca_cfg import fpca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [15:0] cmd_age_r;
  logic [15:0] stop_age_r;
  logic [3:0]  slots_r;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_age_r  <= CMD_AGE_RST;
      stop_age_r <= STOP_AGE_RST;
      slots_r    <= SLOTS_RST;
    end else if (wr) begin
      case (idx)
        REG_CMD_AGE:  cmd_age_r  <= pwdata[15:0];
        REG_STOP_AGE: stop_age_r <= pwdata[15:0];
        REG_SLOTS:    slots_r    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CMD_AGE:  prdata = {16'b0, cmd_age_r};
      REG_STOP_AGE: prdata = {16'b0, stop_age_r};
      REG_SLOTS:    prdata = {28'b0, slots_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.cmd_age  = cmd_age_r;
  assign cfg.stop_age = stop_age_r;
  assign cfg.slots    = slots_r;
  assign cfg.clr      = wr && (idx == REG_CMD_AGE || idx == REG_STOP_AGE || idx == REG_SLOTS);

endmodule

// ===== rtl/fpca_ctrl.sv =====
module fpca_ctrl import fpca_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  input  stat_t      stat,
  output ctl_t       ctl
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ctl       = '0;
    accept    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        accept    = in_valid;
        ctl.apply = accept;
        ctl.latch = accept && (in_command == CMD_EVAL);
        if (ctl.latch) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ctl.check = 1'b1;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (!stat.out_full) begin
          ctl.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fpca_dp.sv =====
module fpca_dp import fpca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  ctl_t      ctl,
  output stat_t     stat,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [NUM_SLOTS-1:0]       slot_valid_r;
  logic [31:0]                slot_time_r     [NUM_SLOTS];
  logic signed [15:0]         slot_steer_r    [NUM_SLOTS];
  logic signed [15:0]         slot_throttle_r [NUM_SLOTS];
  logic signed [15:0]         slot_brake_r    [NUM_SLOTS];
  logic [NUM_STOPS-1:0]       stop_present_r;
  logic [31:0]                stop_time_r     [NUM_STOPS];
  logic [NUM_STOPS-1:0]       stop_ok_r;
  logic signed [15:0]         manual_steer_r;
  logic signed [15:0]         manual_throttle_r;
  logic                       auto_r;
  logic                       relay_r;

  logic [31:0]                now_r;
  logic [NUM_SLOTS-1:0]       elig_r;
  logic [NUM_STOPS-1:0]       stop_fresh_r;
  logic                       out_valid_r;
  out_item_t                  out_r;

  logic [3:0]                 n_eff;
  logic                       cmdr_ok;
  out_item_t                  pick;
  logic                       any_stop;
  logic                       stop_bad;
  logic                       stop_block;
  logic                       motion;
  logic                       t_found;
  logic [3:0]                 t_code;
  logic signed [15:0]         t_val;

  assign n_eff   = (cfg.slots > 4'(NUM_SLOTS)) ? 4'(NUM_SLOTS) : cfg.slots;
  assign cmdr_ok = {1'b0, in_item.slot} < n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r      <= '0;
      stop_present_r    <= '0;
      manual_steer_r    <= '0;
      manual_throttle_r <= '0;
      auto_r            <= 1'b0;
      relay_r           <= 1'b0;
    end else begin
      if (cfg.clr) begin
        slot_valid_r <= '0;
      end else if (ctl.apply) begin
        case (in_item.command)
          CMD_COMMANDER: begin
            if (cmdr_ok) begin
              slot_valid_r[in_item.slot] <= 1'b1;
            end
          end
          CMD_RUNSTOP: begin
            stop_present_r[in_item.slot] <= 1'b1;
          end
          CMD_RC: begin
            manual_steer_r    <= in_item.steer_value;
            manual_throttle_r <= in_item.throttle_value;
            auto_r            <= in_item.auto_mode;
            relay_r           <= in_item.relay_on;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply && in_item.command == CMD_COMMANDER && cmdr_ok) begin
      slot_time_r[in_item.slot]     <= in_item.stamp;
      slot_steer_r[in_item.slot]    <= in_item.steer_value;
      slot_throttle_r[in_item.slot] <= in_item.throttle_value;
      slot_brake_r[in_item.slot]    <= in_item.brake_value;
    end
    if (ctl.apply && in_item.command == CMD_RUNSTOP) begin
      stop_time_r[in_item.slot] <= in_item.stamp;
      stop_ok_r[in_item.slot]   <= in_item.motion_ok;
    end
    if (ctl.latch) begin
      now_r <= in_item.stamp;
    end
    if (ctl.check) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        elig_r[i] <= slot_valid_r[i] && (4'(i) < n_eff) &&
                     is_fresh(now_r, slot_time_r[i], cfg.cmd_age);
      end
      for (int j = 0; j < NUM_STOPS; j++) begin
        stop_fresh_r[j] <= stop_present_r[j] && is_fresh(now_r, stop_time_r[j], cfg.stop_age);
      end
    end
    if (ctl.load) begin
      out_r <= pick;
    end
  end

  always_comb begin
    any_stop   = |stop_present_r;
    stop_bad   = |(stop_fresh_r & ~stop_ok_r);
    stop_block = any_stop && (stop_bad || !(|stop_fresh_r));
    motion     = any_stop && !stop_block;

    pick                 = '0;
    pick.steer_source    = SRC_NONE;
    pick.brake_source    = SRC_NONE;
    t_found              = 1'b0;
    t_code               = SRC_NONE;
    t_val                = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (elig_r[i] && in_unit(slot_steer_r[i])) begin
        pick.steer_source = SRC_SLOT0 + 4'(i);
        pick.out_steer    = slot_steer_r[i];
      end
      if (elig_r[i] && in_brake(slot_brake_r[i])) begin
        pick.brake_source = SRC_SLOT0 + 4'(i);
        pick.out_brake    = slot_brake_r[i];
      end
      if (elig_r[i] && in_unit(slot_throttle_r[i])) begin
        t_found = 1'b1;
        t_code  = SRC_SLOT0 + 4'(i);
        t_val   = slot_throttle_r[i];
      end
    end

    if (stop_block) begin
      pick.throttle_source = SRC_RUNSTOP;
    end else if (motion && t_found) begin
      pick.throttle_source = t_code;
      pick.out_throttle    = t_val;
    end else begin
      pick.throttle_source = SRC_NONE;
    end

    pick.motion_on      = motion;
    pick.autonomous     = auto_r;
    pick.relay_enabled  = relay_r;

    if (!auto_r) begin
      pick.out_steer       = manual_steer_r;
      pick.out_throttle    = manual_throttle_r;
      pick.out_brake       = ZERO_Q;
      pick.steer_source    = SRC_MANUAL;
      pick.throttle_source = SRC_MANUAL;
      pick.brake_source    = SRC_MANUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_full = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

endmodule

// ===== rtl/freshness_priority_command_arbiter_unit.sv =====
// Update transactions (commander, runstop, rc) are taken only in the idle state and leave no result.
// An evaluate transaction latches its stamp when accepted; the freshness compares are then
// registered, and runstop gating and priority selection load the output register.
// No input is taken until that result loads, which waits while an earlier result is stalled.
// Synchronous active-low reset clears all slots, the rc values and flags, and loads
// the register defaults; there is no clearing pass.
module freshness_priority_command_arbiter_unit import fpca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  fpca_in_if.sink            in_ch,
  fpca_out_if.source         out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  cfg_t  cfg;
  ctl_t  ctl;
  stat_t stat;
  logic  in_ready;

  fpca_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  fpca_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.payload.command),
    .in_ready   (in_ready),
    .stat       (stat),
    .ctl        (ctl)
  );

  fpca_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .ctl       (ctl),
    .stat      (stat),
    .in_item   (in_ch.payload),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== rtl/fpca_chk.sv =====
module fpca_chk import fpca_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  logic eval_acc;

  assign eval_acc = in_valid && in_ready && (in_item.command == CMD_EVAL);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    eval_acc |=> !in_ready)
    else $error("input taken during evaluation");

  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(eval_acc, 3))
    else $error("result without a matching evaluate");

  a_manual: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.autonomous |-> out_item.steer_source == SRC_MANUAL &&
      out_item.throttle_source == SRC_MANUAL && out_item.brake_source == SRC_MANUAL &&
      out_item.out_brake == ZERO_Q)
    else $error("manual mode result is wrong");

  a_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.autonomous && !out_item.motion_on |->
      out_item.throttle_source == SRC_NONE || out_item.throttle_source == SRC_RUNSTOP)
    else $error("throttle granted without motion");

endmodule

bind freshness_priority_command_arbiter_unit fpca_chk u_fpca_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_item   (in_ch.payload),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb import fpca_pkg::*; ();

  logic               clk;
  logic               rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  fpca_in_if  in_ch ();
  fpca_out_if out_ch ();

  freshness_priority_command_arbiter_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  int          errors;
  bit          gaps_on;
  bit          stall_on;
  logic [31:0] now_ms;
  out_item_t   pending_results[$];

  logic               cmd_live     [NUM_SLOTS];
  logic [31:0]        cmd_stamp    [NUM_SLOTS];
  logic signed [15:0] cmd_steer    [NUM_SLOTS];
  logic signed [15:0] cmd_throttle [NUM_SLOTS];
  logic signed [15:0] cmd_brake    [NUM_SLOTS];
  logic               stop_live    [NUM_STOPS];
  logic [31:0]        stop_stamp   [NUM_STOPS];
  logic               stop_allows  [NUM_STOPS];
  logic signed [15:0] rc_steer;
  logic signed [15:0] rc_throttle;
  logic               rc_auto;
  logic               rc_relay;
  logic [15:0]        age_limit_cmd;
  logic [15:0]        age_limit_stop;
  logic [3:0]         slot_setting;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_error(string msg);
    errors++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic logic fresh_at(logic [31:0] now, logic [31:0] t, logic [15:0] lim);
    logic [31:0] age;
    age = now - t;
    return age[31] || (age < {16'd0, lim});
  endfunction

  task automatic reset_model();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cmd_live[i]     = 1'b0;
      cmd_stamp[i]    = '0;
      cmd_steer[i]    = '0;
      cmd_throttle[i] = '0;
      cmd_brake[i]    = '0;
    end
    for (int i = 0; i < NUM_STOPS; i++) begin
      stop_live[i]   = 1'b0;
      stop_stamp[i]  = '0;
      stop_allows[i] = 1'b0;
    end
    rc_steer       = '0;
    rc_throttle    = '0;
    rc_auto        = 1'b0;
    rc_relay       = 1'b0;
    age_limit_cmd  = CMD_AGE_RST;
    age_limit_stop = STOP_AGE_RST;
    slot_setting   = SLOTS_RST;
  endtask

  task automatic arbitrate_item(in_item_t it);
    out_item_t r;
    int        n;
    int        fresh_cnt;
    logic      any_stop;
    logic      go;
    logic [3:0] code;
    n = (slot_setting > NUM_SLOTS) ? NUM_SLOTS : int'(slot_setting);
    case (it.command)
      CMD_COMMANDER: begin
        if (int'(it.slot) < n) begin
          cmd_live[it.slot]     = 1'b1;
          cmd_stamp[it.slot]    = it.stamp;
          cmd_steer[it.slot]    = it.steer_value;
          cmd_throttle[it.slot] = it.throttle_value;
          cmd_brake[it.slot]    = it.brake_value;
        end
      end
      CMD_RUNSTOP: begin
        stop_live[it.slot]   = 1'b1;
        stop_stamp[it.slot]  = it.stamp;
        stop_allows[it.slot] = it.motion_ok;
      end
      CMD_RC: begin
        rc_steer    = it.steer_value;
        rc_throttle = it.throttle_value;
        rc_auto     = it.auto_mode;
        rc_relay    = it.relay_on;
      end
      default: begin
        r = '0;
        r.steer_source    = SRC_NONE;
        r.throttle_source = SRC_NONE;
        r.brake_source    = SRC_NONE;
        any_stop  = 1'b0;
        go        = 1'b0;
        fresh_cnt = 0;
        for (int i = 0; i < NUM_STOPS; i++) any_stop |= stop_live[i];
        if (any_stop) begin
          go = 1'b1;
          for (int i = 0; i < NUM_STOPS; i++) begin
            if (stop_live[i] && fresh_at(it.stamp, stop_stamp[i], age_limit_stop)) begin
              fresh_cnt++;
              if (!stop_allows[i]) begin
                go = 1'b0;
                r.throttle_source = SRC_RUNSTOP;
              end
            end
          end
          if (fresh_cnt == 0) begin
            go = 1'b0;
            r.throttle_source = SRC_RUNSTOP;
          end
        end
        for (int i = 0; i < n; i++) begin
          code = SRC_SLOT0 + 4'(i);
          if (cmd_live[i] && fresh_at(it.stamp, cmd_stamp[i], age_limit_cmd)) begin
            if (r.throttle_source == SRC_NONE && go &&
                cmd_throttle[i] <= ONE_Q && cmd_throttle[i] >= NEG_ONE_Q) begin
              r.throttle_source = code;
              r.out_throttle    = cmd_throttle[i];
            end
            if (r.steer_source == SRC_NONE &&
                cmd_steer[i] <= ONE_Q && cmd_steer[i] >= NEG_ONE_Q) begin
              r.steer_source = code;
              r.out_steer    = cmd_steer[i];
            end
            if (r.brake_source == SRC_NONE &&
                cmd_brake[i] <= ONE_Q && cmd_brake[i] >= ZERO_Q) begin
              r.brake_source = code;
              r.out_brake    = cmd_brake[i];
            end
          end
        end
        if (!rc_auto) begin
          r.out_steer       = rc_steer;
          r.out_throttle    = rc_throttle;
          r.out_brake       = ZERO_Q;
          r.steer_source    = SRC_MANUAL;
          r.throttle_source = SRC_MANUAL;
          r.brake_source    = SRC_MANUAL;
        end
        r.motion_on      = go;
        r.autonomous     = rc_auto;
        r.relay_enabled  = rc_relay;
        pending_results.insert(pending_results.size(), r);
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (pending_results.size() == 0) begin
          report_error("result transaction with no evaluate pending");
        end else begin
          want = pending_results.pop_front();
          check_field("out_steer", got.out_steer, want.out_steer);
          check_field("out_throttle", got.out_throttle, want.out_throttle);
          check_field("out_brake", got.out_brake, want.out_brake);
          check_field("steer_source", got.steer_source, want.steer_source);
          check_field("throttle_source", got.throttle_source, want.throttle_source);
          check_field("brake_source", got.brake_source, want.brake_source);
          check_field("motion_on", got.motion_on, want.motion_on);
          check_field("autonomous", got.autonomous, want.autonomous);
          check_field("relay_enabled", got.relay_enabled, want.relay_enabled);
        end
      end
      if (in_ch.valid && in_ch.ready) arbitrate_item(in_ch.payload);
    end
  end

  always begin
    @(posedge clk);
    if (stall_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(0, 16)) @(posedge clk);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(in_item_t it);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] keep;
    logic [31:0] got;
    keep = (idx == REG_SLOTS) ? (value & 32'hF) : (value & 32'hFFFF);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_CMD_AGE:  age_limit_cmd  = keep[15:0];
      REG_STOP_AGE: age_limit_stop = keep[15:0];
      default:      slot_setting   = keep[3:0];
    endcase
    for (int i = 0; i < NUM_SLOTS; i++) cmd_live[i] = 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    if (got !== keep) begin
      report_error($sformatf("register %0d read %0h, expected %0h", idx, got, keep));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [15:0] cmd_age, logic [15:0] stop_age, logic [3:0] slots);
    settle();
    write_reg(REG_CMD_AGE, {16'($urandom), cmd_age});
    write_reg(REG_STOP_AGE, {16'($urandom), stop_age});
    write_reg(REG_SLOTS, {28'($urandom), slots});
  endtask

  function automatic in_item_t pack_item(logic [1:0] c, logic [2:0] s,
                                         logic signed [15:0] sv, logic signed [15:0] tv,
                                         logic signed [15:0] bv, logic mok, logic am,
                                         logic ro, logic [31:0] st);
    in_item_t it;
    it.command        = c;
    it.slot           = s;
    it.steer_value    = sv;
    it.throttle_value = tv;
    it.brake_value    = bv;
    it.motion_ok      = mok;
    it.auto_mode      = am;
    it.relay_on       = ro;
    it.stamp          = st;
    return it;
  endfunction

  function automatic logic signed [15:0] pick_value(bit brake);
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'($urandom);
      1: v = ONE_Q + 16'sd1;
      2: v = brake ? 16'hFFFF : NEG_ONE_Q - 16'sd1;
      3: v = ONE_Q;
      4: v = brake ? ZERO_Q : NEG_ONE_Q;
      default: v = brake ? 16'($urandom_range(0, 8192)) : 16'($urandom_range(0, 16384) - 8192);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] stamp_near(logic [15:0] lim);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return now_ms + $urandom_range(1, 500);
      2: return now_ms - lim;
      default: return now_ms - $urandom_range(0, 2 * lim + 2);
    endcase
  endfunction

  task automatic random_item(output in_item_t it);
    int pick;
    now_ms += $urandom_range(0, 20);
    it.command        = 2'($urandom);
    it.slot           = 3'($urandom);
    it.steer_value    = 16'($urandom);
    it.throttle_value = 16'($urandom);
    it.brake_value    = 16'($urandom);
    it.motion_ok      = 1'($urandom);
    it.auto_mode      = 1'($urandom);
    it.relay_on       = 1'($urandom);
    it.stamp          = $urandom;
    if ($urandom_range(0, 9) != 0) begin
      pick = $urandom_range(0, 19);
      it.steer_value    = pick_value(1'b0);
      it.throttle_value = pick_value(1'b0);
      it.brake_value    = pick_value(1'b1);
      it.motion_ok      = ($urandom_range(0, 24) != 0);
      it.auto_mode      = ($urandom_range(0, 6) != 0);
      if (pick < 7) begin
        it.command = CMD_COMMANDER;
        it.stamp   = stamp_near(age_limit_cmd);
      end else if (pick < 10) begin
        it.command = CMD_RUNSTOP;
        if ($urandom_range(0, 3) != 0) it.slot = 3'($urandom_range(0, 1));
        it.stamp = stamp_near(age_limit_stop);
      end else if (pick < 12) begin
        it.command = CMD_RC;
      end else begin
        it.command = CMD_EVAL;
        it.stamp   = now_ms;
      end
    end
  endtask

  task automatic run_random(int count);
    in_item_t it;
    for (int k = 0; k < count; k++) begin
      random_item(it);
      send_item(it);
    end
  endtask

  task automatic test_directed_cases();
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 1000));
    send_item(pack_item(CMD_RC, 0, -32768, 32767, 0, 0, 0, 1, 0));
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 1000));
    send_item(pack_item(CMD_RC, 0, 0, 0, 0, 0, 1, 0, 0));
    send_item(pack_item(CMD_COMMANDER, 0, 8192, -8192, 0, 0, 0, 0, 1000));
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 1100));
    send_item(pack_item(CMD_RUNSTOP, 7, 0, 0, 0, 1, 0, 0, 1000));
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 1100));
    send_item(pack_item(CMD_COMMANDER, 1, 8193, 8193, -1, 0, 0, 0, 1100));
    send_item(pack_item(CMD_COMMANDER, 0, -8193, 32767, 8193, 0, 0, 0, 1100));
    send_item(pack_item(CMD_COMMANDER, 2, -8192, 8192, 8192, 0, 0, 0, 1100));
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 1150));
    send_item(pack_item(CMD_COMMANDER, 6, 100, 100, 100, 0, 0, 0, 1150));
    send_item(pack_item(CMD_COMMANDER, 7, 200, 200, 200, 0, 0, 0, 1150));
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 1300));
    send_item(pack_item(CMD_COMMANDER, 5, 1, 2, 3, 0, 0, 0, 5000));
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 1300));
    send_item(pack_item(CMD_RUNSTOP, 0, 0, 0, 0, 0, 0, 0, 1300));
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 1300));
    send_item(pack_item(CMD_RUNSTOP, 0, 0, 0, 0, 1, 0, 0, 1300));
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 3300));
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 3299));
    send_item(pack_item(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
  endtask

  task automatic test_register_extremes();
    configure(16'd0, 16'd0, 4'd0);
    now_ms = $urandom;
    run_random(40);
    configure(16'hFFFF, 16'hFFFF, 4'd8);
    now_ms = $urandom;
    run_random(40);
    configure(16'd1, 16'hFFFF, 4'd15);
    now_ms = $urandom;
    run_random(40);
    configure(CMD_AGE_RST, STOP_AGE_RST, SLOTS_RST);
    now_ms = $urandom;
    run_random(40);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      configure(16'($urandom_range(20, 1000)), 16'($urandom_range(50, 3000)),
                4'($urandom_range(0, 15)));
      now_ms = (phase == 1) ? 32'hFFFF_F000 : $urandom;
      run_random(125);
      if (phase == 2) settle();
      run_random(125);
    end
  endtask

  task automatic test_back_to_back();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    configure(16'($urandom_range(100, 600)), 16'($urandom_range(500, 3000)), 4'd8);
    now_ms = $urandom;
    run_random(300);
  endtask

  initial begin
    int waited;
    errors        = 0;
    gaps_on       = 1'b1;
    stall_on      = 1'b1;
    now_ms        = '0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    out_ch.ready  <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_register_extremes();
    test_random_traffic();
    test_back_to_back();

    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_error($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
